### rtl/core/wscs_pkg.sv
// Package for the wave solder cycle sequencer.
// Holds the phase encoding, drive bit positions, register indexes and result type.
// No dependencies.
package wscs_pkg;

    // One-hot phase register encoding.
    typedef enum logic [11:0] {
        PH_INIT      = 12'b0000_0000_0001,
        PH_IDLE      = 12'b0000_0000_0010,
        PH_READY     = 12'b0000_0000_0100,
        PH_ARRIVE    = 12'b0000_0000_1000,
        PH_FLUX      = 12'b0000_0001_0000,
        PH_TO_PREHT  = 12'b0000_0010_0000,
        PH_PREHEAT   = 12'b0000_0100_0000,
        PH_TO_WAVE   = 12'b0000_1000_0000,
        PH_WAVE      = 12'b0001_0000_0000,
        PH_COOLING   = 12'b0010_0000_0000,
        PH_COOL_DONE = 12'b0100_0000_0000,
        PH_FINISHED  = 12'b1000_0000_0000
    } phase_t;

    // Bit positions in the drive and lamp latch.
    localparam int D_TRAVEL = 0;
    localparam int D_FLUX   = 1;
    localparam int D_PUMP   = 2;
    localparam int D_COOL   = 3;
    localparam int L_GREEN  = 4;
    localparam int L_AMBER  = 5;
    localparam int L_RED    = 6;

    // Bit positions in the debounced sample.
    localparam int B_STOP    = 0;
    localparam int B_COOLIN  = 1;
    localparam int B_PREHIN  = 2;
    localparam int B_FLUXEND = 3;
    localparam int B_READY   = 4;
    localparam int B_START   = 5;
    localparam int B_RESTART = 7;

    // Bit positions in the rising-edge latch.
    localparam int E_STOP    = 0;
    localparam int E_START   = 1;
    localparam int E_RESTART = 2;

    localparam int TIMER_W = 21;

    localparam logic [9:0] TIME_SCALE_RESET = 10'd351;
    localparam logic [7:0] TICK_MS_RESET    = 8'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIME_SCALE = 2'd0;
    localparam logic [1:0] CFG_TICK_MS    = 2'd1;

    typedef struct packed {
        logic [6:0] drives;
        logic       paused;
        logic [3:0] phase;
    } result_t;

    function automatic logic [3:0] phase_code(input phase_t ph);
        logic [3:0] code;
        code = 4'd0;
        unique case (ph)
            PH_INIT:      code = 4'd0;
            PH_IDLE:      code = 4'd1;
            PH_READY:     code = 4'd2;
            PH_ARRIVE:    code = 4'd3;
            PH_FLUX:      code = 4'd4;
            PH_TO_PREHT:  code = 4'd5;
            PH_PREHEAT:   code = 4'd6;
            PH_TO_WAVE:   code = 4'd7;
            PH_WAVE:      code = 4'd8;
            PH_COOLING:   code = 4'd9;
            PH_COOL_DONE: code = 4'd10;
            PH_FINISHED:  code = 4'd11;
            default:      code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/wave_solder_cycle_sequencer.sv
// Wave solder cycle sequencer: debounce, edge latching, pause and the phase sequence.
// Results are registered in a single stage after the phase logic (output or skid register).
// Throughput: one request per cycle while the skid entry is empty; a two-entry output buffer
// keeps input ready high while one result waits.
// Reset: phase init, drives, latches and timers clear, registers take their defaults;
// the first request after reset only loads the debounce history.
// Depends on wscs_pkg.
module wave_solder_cycle_sequencer #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [6:0] switch_bits,
    input  logic       restart_in,
    input  logic [9:0] preheat_pot,
    input  logic [9:0] cool_pot,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       travel_drive,
    output logic       flux_drive,
    output logic       pump_drive,
    output logic       cool_drive,
    output logic       led_green,
    output logic       led_amber,
    output logic       led_red,
    output logic       paused,
    output logic [3:0] phase
);

    localparam int TW = wscs_pkg::TIMER_W;

    // Configuration registers
    logic [9:0] time_scale_reg;
    logic [7:0] tick_ms_reg;

    // Sequencer state
    logic [7:0]       hist_reg [HISTORY_DEPTH];
    logic [7:0]       hist_next [HISTORY_DEPTH];
    logic [7:0]       deb_reg, deb_next;
    logic [2:0]       rise_reg, rise_next;
    logic             primed_reg;
    logic             pause_reg, pause_next;
    wscs_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]    timer_reg, timer_next;
    logic [7:0]       blink_reg, blink_next;
    logic [6:0]       drive_reg, drive_next;

    // Output buffer
    logic               out_valid_reg;
    wscs_pkg::result_t  out_reg;
    logic               skid_valid_reg;
    wscs_pkg::result_t  skid_reg;
    wscs_pkg::result_t  result_next;

    logic accept;
    logic fire_out;

    logic [7:0]  sample;
    logic [7:0]  all1, any1, rise;
    logic [9:0]  pot_sel;
    logic [19:0] limit;
    logic        timer_done;
    logic        blink_on;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~skid_valid_reg;
    assign accept    = in_valid & in_ready;
    assign fire_out  = out_valid_reg & out_ready;

    assign sample = {restart_in, switch_bits};

    always_comb
    begin
        all1 = sample;
        any1 = sample;
        for (int i = 0; i < HISTORY_DEPTH - 1; i++)
        begin
            all1 = all1 & hist_reg[i];
            any1 = any1 | hist_reg[i];
        end
    end

    // Newest sample sits at slot zero; the priming request fills every slot.
    always_comb
    begin
        hist_next[0] = sample;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            hist_next[i] = primed_reg ? hist_reg[i-1] : sample;
        end
    end

    // Only one of the two timed phases can be active, so they share one multiplier.
    assign pot_sel    = (phase_reg == wscs_pkg::PH_COOLING) ? cool_pot : preheat_pot;
    assign limit      = 20'(time_scale_reg) * 20'(pot_sel);
    assign timer_done = (timer_reg >= {1'b0, limit});
    assign blink_on   = ~blink_reg[6];

    always_comb
    begin
        deb_next   = deb_reg;
        rise_next  = rise_reg;
        pause_next = pause_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        blink_next = blink_reg;
        drive_next = drive_reg;
        rise       = 8'd0;

        if (!primed_reg)
        begin
            deb_next = sample;
        end
        else
        begin
            deb_next = (~deb_reg & all1) | (deb_reg & any1);
            rise     = ~deb_reg & deb_next;
            rise_next[wscs_pkg::E_STOP]    = rise_reg[wscs_pkg::E_STOP]
                                             | rise[wscs_pkg::B_STOP];
            rise_next[wscs_pkg::E_START]   = rise_reg[wscs_pkg::E_START]
                                             | rise[wscs_pkg::B_START];
            rise_next[wscs_pkg::E_RESTART] = rise_reg[wscs_pkg::E_RESTART]
                                             | rise[wscs_pkg::B_RESTART];

            if (rise_next[wscs_pkg::E_RESTART])
            begin
                rise_next[wscs_pkg::E_RESTART] = 1'b0;
                drive_next = 7'd0;
                drive_next[wscs_pkg::L_RED] = 1'b1;
                phase_next = wscs_pkg::PH_IDLE;
            end
            else if (rise_next[wscs_pkg::E_STOP])
            begin
                rise_next[wscs_pkg::E_STOP] = 1'b0;
                pause_next = ~pause_reg;
            end
            else if (pause_reg)
            begin
                drive_next[wscs_pkg::L_GREEN] = blink_on;
                blink_next = blink_reg + 8'd1;
                drive_next[wscs_pkg::D_COOL:wscs_pkg::D_TRAVEL] = 4'd0;
            end
            else
            begin
                unique case (phase_reg)
                    wscs_pkg::PH_INIT:
                    begin
                        phase_next = wscs_pkg::PH_IDLE;
                    end
                    wscs_pkg::PH_IDLE:
                    begin
                        drive_next[wscs_pkg::L_RED]   = 1'b1;
                        drive_next[wscs_pkg::L_GREEN] = 1'b0;
                        drive_next[wscs_pkg::L_AMBER] = 1'b0;
                        if (deb_next[wscs_pkg::B_READY])
                        begin
                            phase_next = wscs_pkg::PH_READY;
                        end
                    end
                    wscs_pkg::PH_READY:
                    begin
                        drive_next[wscs_pkg::L_RED]   = 1'b1;
                        drive_next[wscs_pkg::L_GREEN] = 1'b0;
                        if (deb_next[wscs_pkg::B_READY] && !deb_next[wscs_pkg::B_COOLIN]
                            && rise_next[wscs_pkg::E_START])
                        begin
                            rise_next[wscs_pkg::E_START]   = 1'b0;
                            drive_next[wscs_pkg::D_TRAVEL] = 1'b1;
                            phase_next = wscs_pkg::PH_ARRIVE;
                        end
                    end
                    wscs_pkg::PH_ARRIVE:
                    begin
                        drive_next[wscs_pkg::L_RED]    = 1'b0;
                        drive_next[wscs_pkg::L_GREEN]  = 1'b1;
                        drive_next[wscs_pkg::D_TRAVEL] = 1'b1;
                        if (!deb_next[wscs_pkg::B_READY])
                        begin
                            phase_next = wscs_pkg::PH_FLUX;
                            drive_next[wscs_pkg::D_FLUX] = 1'b1;
                        end
                    end
                    wscs_pkg::PH_FLUX:
                    begin
                        drive_next[wscs_pkg::L_GREEN]  = 1'b1;
                        drive_next[wscs_pkg::D_TRAVEL] = 1'b1;
                        drive_next[wscs_pkg::D_FLUX]   = 1'b1;
                        if (deb_next[wscs_pkg::B_FLUXEND])
                        begin
                            drive_next[wscs_pkg::D_FLUX] = 1'b0;
                            phase_next = wscs_pkg::PH_TO_PREHT;
                        end
                    end
                    wscs_pkg::PH_TO_PREHT:
                    begin
                        drive_next[wscs_pkg::L_GREEN] = 1'b1;
                        if (deb_next[wscs_pkg::B_PREHIN])
                        begin
                            drive_next[wscs_pkg::D_TRAVEL] = 1'b0;
                            timer_next = '0;
                            blink_next = 8'd0;
                            phase_next = wscs_pkg::PH_PREHEAT;
                        end
                    end
                    wscs_pkg::PH_PREHEAT:
                    begin
                        drive_next[wscs_pkg::L_GREEN] = 1'b1;
                        drive_next[wscs_pkg::L_AMBER] = blink_on;
                        blink_next = blink_reg + 8'd1;
                        if (timer_done)
                        begin
                            drive_next[wscs_pkg::D_TRAVEL] = 1'b1;
                            drive_next[wscs_pkg::L_AMBER]  = 1'b0;
                            phase_next = wscs_pkg::PH_TO_WAVE;
                        end
                        else
                        begin
                            timer_next = timer_reg + TW'(tick_ms_reg);
                        end
                    end
                    wscs_pkg::PH_TO_WAVE:
                    begin
                        drive_next[wscs_pkg::L_GREEN]  = 1'b1;
                        drive_next[wscs_pkg::D_TRAVEL] = 1'b1;
                        if (!deb_next[wscs_pkg::B_PREHIN])
                        begin
                            drive_next[wscs_pkg::D_PUMP] = 1'b1;
                            phase_next = wscs_pkg::PH_WAVE;
                        end
                    end
                    wscs_pkg::PH_WAVE:
                    begin
                        drive_next[wscs_pkg::L_GREEN] = 1'b1;
                        drive_next[wscs_pkg::D_PUMP]  = 1'b1;
                        if (deb_next[wscs_pkg::B_COOLIN])
                        begin
                            drive_next[wscs_pkg::D_PUMP]   = 1'b0;
                            drive_next[wscs_pkg::D_TRAVEL] = 1'b0;
                            drive_next[wscs_pkg::D_COOL]   = 1'b1;
                            timer_next = '0;
                            blink_next = 8'd0;
                            phase_next = wscs_pkg::PH_COOLING;
                        end
                    end
                    wscs_pkg::PH_COOLING:
                    begin
                        drive_next[wscs_pkg::D_COOL]  = 1'b1;
                        drive_next[wscs_pkg::L_GREEN] = 1'b1;
                        drive_next[wscs_pkg::L_AMBER] = blink_on;
                        blink_next = blink_reg + 8'd1;
                        if (timer_done)
                        begin
                            drive_next[wscs_pkg::D_COOL]  = 1'b0;
                            drive_next[wscs_pkg::L_AMBER] = 1'b0;
                            phase_next = wscs_pkg::PH_COOL_DONE;
                        end
                        else
                        begin
                            timer_next = timer_reg + TW'(tick_ms_reg);
                        end
                    end
                    wscs_pkg::PH_COOL_DONE:
                    begin
                        drive_next[wscs_pkg::L_GREEN] = 1'b1;
                        if (!deb_next[wscs_pkg::B_COOLIN])
                        begin
                            phase_next = wscs_pkg::PH_FINISHED;
                        end
                    end
                    wscs_pkg::PH_FINISHED:
                    begin
                        drive_next[wscs_pkg::L_GREEN] = 1'b0;
                        drive_next[wscs_pkg::L_RED]   = blink_on;
                        blink_next = blink_reg + 8'd1;
                        if (deb_next[wscs_pkg::B_READY])
                        begin
                            phase_next = wscs_pkg::PH_READY;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign result_next.drives = drive_next;
    assign result_next.paused = pause_next;
    assign result_next.phase  = wscs_pkg::phase_code(phase_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg <= wscs_pkg::TIME_SCALE_RESET;
            tick_ms_reg    <= wscs_pkg::TICK_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wscs_pkg::CFG_TIME_SCALE: time_scale_reg <= cfg_data;
                wscs_pkg::CFG_TICK_MS:    tick_ms_reg    <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            rise_reg   <= 3'd0;
            pause_reg  <= 1'b0;
            phase_reg  <= wscs_pkg::PH_INIT;
            timer_reg  <= '0;
            blink_reg  <= 8'd0;
            drive_reg  <= 7'd0;
        end
        else if (accept)
        begin
            primed_reg <= 1'b1;
            rise_reg   <= rise_next;
            pause_reg  <= pause_next;
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            blink_reg  <= blink_next;
            drive_reg  <= drive_next;
        end
    end

    // Debounce history and level carry no reset; the priming request loads them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            deb_reg <= deb_next;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (fire_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= result_next;
            end
            else
            begin
                out_reg <= result_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign travel_drive = out_reg.drives[wscs_pkg::D_TRAVEL];
    assign flux_drive   = out_reg.drives[wscs_pkg::D_FLUX];
    assign pump_drive   = out_reg.drives[wscs_pkg::D_PUMP];
    assign cool_drive   = out_reg.drives[wscs_pkg::D_COOL];
    assign led_green    = out_reg.drives[wscs_pkg::L_GREEN];
    assign led_amber    = out_reg.drives[wscs_pkg::L_AMBER];
    assign led_red      = out_reg.drives[wscs_pkg::L_RED];
    assign paused       = out_reg.paused;
    assign phase        = out_reg.phase;

endmodule

### tb/wscs_tick_checker.sv
// Result checker for the wave solder cycle sequencer test.
// Tracks every accepted request in its own copy of the controller and compares each result.
// Depends on wscs_pkg; instantiated by wave_solder_cycle_sequencer_test.
module wscs_tick_checker (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,

    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [6:0] switch_bits,
    input  logic       restart_in,
    input  logic [9:0] preheat_pot,
    input  logic [9:0] cool_pot,

    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       travel_drive,
    input  logic       flux_drive,
    input  logic       pump_drive,
    input  logic       cool_drive,
    input  logic       led_green,
    input  logic       led_amber,
    input  logic       led_red,
    input  logic       paused,
    input  logic [3:0] phase,

    output int         pending,
    output int         fail_count
);

    localparam int DEPTH = 8;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READY,
        ST_ARRIVE,
        ST_FLUX,
        ST_TO_PREHEAT,
        ST_PREHEAT,
        ST_TO_WAVE,
        ST_WAVE,
        ST_COOLING,
        ST_COOL_DONE,
        ST_FINISHED
    } stage_t;

    typedef struct packed {
        logic [6:0] lamps;
        logic       paused;
        logic [3:0] stage;
    } tick_result_t;

    string lamp_name [7] = '{"travel_drive", "flux_drive", "pump_drive", "cool_drive",
                             "led_green", "led_amber", "led_red"};

    logic [9:0]   scale;
    logic [7:0]   tick_step;
    logic [7:0]   hist [DEPTH];
    logic [2:0]   slot;
    logic [7:0]   deb;
    logic [2:0]   edges;
    bit           primed;
    bit           pause_on;
    stage_t       stage;
    logic [20:0]  timer;
    logic [7:0]   blink;
    logic [6:0]   lamps;
    tick_result_t expected_q [$];
    int           result_no;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic clear_model();
        int i;
        scale     = wscs_pkg::TIME_SCALE_RESET;
        tick_step = wscs_pkg::TICK_MS_RESET;
        for (i = 0; i < DEPTH; i++)
            hist[i] = '0;
        slot     = '0;
        deb      = '0;
        edges    = '0;
        primed   = 1'b0;
        pause_on = 1'b0;
        stage    = ST_INIT;
        timer    = '0;
        blink    = '0;
        lamps    = '0;
    endtask

    // The blink lamp is lit during the first half of each 128-tick period.
    function automatic logic blink_step();
        blink_step = ~blink[6];
        blink = blink + 8'd1;
    endfunction

    task automatic timed_step(input logic [9:0] pot, input stage_t done, input bit cooling);
        logic [20:0] lim;
        lim = scale * pot;
        lamps[wscs_pkg::L_GREEN] = 1'b1;
        lamps[wscs_pkg::L_AMBER] = blink_step();
        if (timer >= lim)
        begin
            if (cooling)
                lamps[wscs_pkg::D_COOL] = 1'b0;
            else
                lamps[wscs_pkg::D_TRAVEL] = 1'b1;
            lamps[wscs_pkg::L_AMBER] = 1'b0;
            stage = done;
        end
        else
        begin
            timer = timer + tick_step;
        end
    endtask

    task automatic run_stage(input logic [9:0] pre, input logic [9:0] cool);
        case (stage)
            ST_INIT:
                stage = ST_IDLE;
            ST_IDLE:
            begin
                lamps[wscs_pkg::L_RED]   = 1'b1;
                lamps[wscs_pkg::L_GREEN] = 1'b0;
                lamps[wscs_pkg::L_AMBER] = 1'b0;
                if (deb[wscs_pkg::B_READY])
                    stage = ST_READY;
            end
            ST_READY:
            begin
                lamps[wscs_pkg::L_RED]   = 1'b1;
                lamps[wscs_pkg::L_GREEN] = 1'b0;
                if (deb[wscs_pkg::B_READY] && !deb[wscs_pkg::B_COOLIN]
                    && edges[wscs_pkg::E_START])
                begin
                    edges[wscs_pkg::E_START]  = 1'b0;
                    lamps[wscs_pkg::D_TRAVEL] = 1'b1;
                    stage = ST_ARRIVE;
                end
            end
            ST_ARRIVE:
            begin
                lamps[wscs_pkg::L_RED]    = 1'b0;
                lamps[wscs_pkg::L_GREEN]  = 1'b1;
                lamps[wscs_pkg::D_TRAVEL] = 1'b1;
                if (!deb[wscs_pkg::B_READY])
                begin
                    stage = ST_FLUX;
                    lamps[wscs_pkg::D_FLUX] = 1'b1;
                end
            end
            ST_FLUX:
            begin
                lamps[wscs_pkg::L_GREEN]  = 1'b1;
                lamps[wscs_pkg::D_TRAVEL] = 1'b1;
                lamps[wscs_pkg::D_FLUX]   = 1'b1;
                if (deb[wscs_pkg::B_FLUXEND])
                begin
                    lamps[wscs_pkg::D_FLUX] = 1'b0;
                    stage = ST_TO_PREHEAT;
                end
            end
            ST_TO_PREHEAT:
            begin
                lamps[wscs_pkg::L_GREEN] = 1'b1;
                if (deb[wscs_pkg::B_PREHIN])
                begin
                    lamps[wscs_pkg::D_TRAVEL] = 1'b0;
                    timer = '0;
                    blink = '0;
                    stage = ST_PREHEAT;
                end
            end
            ST_PREHEAT:
                timed_step(pre, ST_TO_WAVE, 1'b0);
            ST_TO_WAVE:
            begin
                lamps[wscs_pkg::L_GREEN]  = 1'b1;
                lamps[wscs_pkg::D_TRAVEL] = 1'b1;
                if (!deb[wscs_pkg::B_PREHIN])
                begin
                    lamps[wscs_pkg::D_PUMP] = 1'b1;
                    stage = ST_WAVE;
                end
            end
            ST_WAVE:
            begin
                lamps[wscs_pkg::L_GREEN] = 1'b1;
                lamps[wscs_pkg::D_PUMP]  = 1'b1;
                if (deb[wscs_pkg::B_COOLIN])
                begin
                    lamps[wscs_pkg::D_PUMP]   = 1'b0;
                    lamps[wscs_pkg::D_TRAVEL] = 1'b0;
                    lamps[wscs_pkg::D_COOL]   = 1'b1;
                    timer = '0;
                    blink = '0;
                    stage = ST_COOLING;
                end
            end
            ST_COOLING:
            begin
                lamps[wscs_pkg::D_COOL] = 1'b1;
                timed_step(cool, ST_COOL_DONE, 1'b1);
            end
            ST_COOL_DONE:
            begin
                lamps[wscs_pkg::L_GREEN] = 1'b1;
                if (!deb[wscs_pkg::B_COOLIN])
                    stage = ST_FINISHED;
            end
            ST_FINISHED:
            begin
                lamps[wscs_pkg::L_GREEN] = 1'b0;
                lamps[wscs_pkg::L_RED]   = blink_step();
                if (deb[wscs_pkg::B_READY])
                    stage = ST_READY;
            end
            default:
                ;
        endcase
    endtask

    task automatic advance(input logic [7:0] sample, input logic [9:0] pre,
                           input logic [9:0] cool, output tick_result_t res);
        logic [7:0] all1;
        logic [7:0] any1;
        logic [7:0] nxt;
        logic [7:0] rise;
        int         i;
        if (!primed)
        begin
            // The first request after reset only fills the history.
            for (i = 0; i < DEPTH; i++)
                hist[i] = sample;
            deb    = sample;
            primed = 1'b1;
        end
        else
        begin
            slot = 3'((slot + 1) % DEPTH);
            hist[slot] = sample;
            all1 = 8'hFF;
            any1 = 8'h00;
            for (i = 0; i < DEPTH; i++)
            begin
                all1 = all1 & hist[i];
                any1 = any1 | hist[i];
            end
            nxt  = (~deb & all1) | (deb & any1);
            rise = ~deb & nxt;
            if (rise[wscs_pkg::B_STOP])
                edges[wscs_pkg::E_STOP] = 1'b1;
            if (rise[wscs_pkg::B_START])
                edges[wscs_pkg::E_START] = 1'b1;
            if (rise[wscs_pkg::B_RESTART])
                edges[wscs_pkg::E_RESTART] = 1'b1;
            deb = nxt;

            if (edges[wscs_pkg::E_RESTART])
            begin
                // Restart leaves the pause flag alone.
                edges[wscs_pkg::E_RESTART] = 1'b0;
                lamps = '0;
                lamps[wscs_pkg::L_RED] = 1'b1;
                stage = ST_IDLE;
            end
            else if (edges[wscs_pkg::E_STOP])
            begin
                edges[wscs_pkg::E_STOP] = 1'b0;
                pause_on = !pause_on;
            end
            else if (pause_on)
            begin
                lamps[wscs_pkg::L_GREEN] = blink_step();
                lamps[wscs_pkg::D_COOL:wscs_pkg::D_TRAVEL] = '0;
            end
            else
            begin
                run_stage(pre, cool);
            end
        end
        res.lamps  = lamps;
        res.paused = pause_on;
        res.stage  = stage;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        tick_result_t fresh;
        logic [6:0]   got;
        int           i;
        if (!rst_n)
        begin
            clear_model();
            expected_q.delete();
            pending    = 0;
            fail_count = 0;
            result_no  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wscs_pkg::CFG_TIME_SCALE: scale     = cfg_data;
                    wscs_pkg::CFG_TICK_MS:    tick_step = cfg_data[7:0];
                    default:                  ;
                endcase
            end

            // Each result is registered after its request is accepted, so compare first.
            if (out_valid && out_ready)
            begin
                got = {led_red, led_amber, led_green, cool_drive, pump_drive, flux_drive,
                       travel_drive};
                if (expected_q.size() == 0)
                begin
                    report($sformatf("result %0d arrived with no request outstanding",
                                     result_no));
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (i = 0; i < 7; i++)
                        if (got[i] !== want.lamps[i])
                            report($sformatf("result %0d %s got %b expected %b", result_no,
                                             lamp_name[i], got[i], want.lamps[i]));
                    if (paused !== want.paused)
                        report($sformatf("result %0d paused got %b expected %b", result_no,
                                         paused, want.paused));
                    if (phase !== want.stage)
                        report($sformatf("result %0d phase got %0d expected %0d", result_no,
                                         phase, want.stage));
                end
                result_no++;
            end

            if (in_valid && in_ready)
            begin
                advance({restart_in, switch_bits}, preheat_pot, cool_pot, fresh);
                expected_q.push_back(fresh);
            end
            pending = expected_q.size();
        end
    end

endmodule

### tb/wave_solder_cycle_sequencer_test.sv
// Top of the wave solder cycle sequencer test: clock, reset, request stimulus and verdict.
// Drives directed ticks, then machine cycles with random interruptions and noise.
// Depends on wscs_pkg, wave_solder_cycle_sequencer and wscs_tick_checker.
module wave_solder_cycle_sequencer_test;

    localparam int LIMIT       = 200000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 6;

    // Indexes that decode to no register.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [6:0] switch_bits = '0;
    logic       restart_in = 1'b0;
    logic [9:0] preheat_pot = '0;
    logic [9:0] cool_pot = '0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic       travel_drive;
    logic       flux_drive;
    logic       pump_drive;
    logic       cool_drive;
    logic       led_green;
    logic       led_amber;
    logic       led_red;
    logic       paused;
    logic [3:0] phase;
    int         pending;
    int         fail_count;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         pot_cap = 2;
    int         sent = 0;
    logic [6:0] sw = '0;
    logic       rst_btn = 1'b0;
    logic       last_paused = 1'b0;

    wave_solder_cycle_sequencer u_dut (.*);

    wscs_tick_checker u_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;

    // Lets the stimulus steer out of a pause left behind by random switch states.
    always @(posedge clk)
        if (out_valid && out_ready)
            last_paused <= paused;

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_tick(input logic [6:0] bits, input logic rbtn,
                             input logic [9:0] pre, input logic [9:0] cool);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        switch_bits = bits;
        restart_in  = rbtn;
        preheat_pot = pre;
        cool_pot    = cool;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    // Mostly readings capped so that scale times reading is at most 150 tick steps.
    function automatic logic [9:0] pick_pot();
        if ($urandom_range(9) == 0)
            return 10'($urandom_range(1023));
        return 10'($urandom_range(pot_cap));
    endfunction

    task automatic hold(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                send_tick(sw ^ (7'd1 << $urandom_range(6)), 1'($urandom_range(1)),
                          pick_pot(), pick_pot());
            else
                send_tick(sw, rst_btn, pick_pot(), pick_pot());
        end
    endtask

    task automatic pulse(input int bitpos);
        sw[bitpos] = 1'b1;
        hold($urandom_range(12, 8));
        sw[bitpos] = 1'b0;
        hold($urandom_range(12, 8));
    endtask

    task automatic press_restart();
        rst_btn = 1'b1;
        hold($urandom_range(12, 8));
        rst_btn = 1'b0;
        hold($urandom_range(12, 8));
    endtask

    task automatic interrupt();
        int r;
        r = $urandom_range(99);
        if (r < 4)
        begin
            // Pause, sometimes restart while paused, then resume.
            pulse(wscs_pkg::B_STOP);
            if ($urandom_range(1))
                press_restart();
            pulse(wscs_pkg::B_STOP);
        end
        else if (r < 7)
            press_restart();
        else if (r < 12)
            pulse(wscs_pkg::B_START);
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_timing(input logic [9:0] scale, input logic [9:0] tick_data);
        write_reg(wscs_pkg::CFG_TIME_SCALE, scale);
        write_reg(wscs_pkg::CFG_TICK_MS, tick_data);
        pot_cap = (tick_data[7:0] * 150) / ((scale == 0) ? 1 : scale);
        if (pot_cap > 1023)
            pot_cap = 1023;
    endtask

    task automatic run_cycle();
        logic was_paused;
        wait_drain();
        was_paused = last_paused;
        rst_btn = 1'b0;
        sw = '0;
        sw[wscs_pkg::B_READY] = 1'b1;
        hold($urandom_range(12, 8));
        if (was_paused)
            pulse(wscs_pkg::B_STOP);
        pulse(wscs_pkg::B_START);
        interrupt();
        sw[wscs_pkg::B_READY] = 1'b0;
        hold($urandom_range(12, 8));
        interrupt();
        sw[wscs_pkg::B_FLUXEND] = 1'b1;
        hold($urandom_range(12, 8));
        sw[wscs_pkg::B_FLUXEND] = 1'b0;
        interrupt();
        sw[wscs_pkg::B_PREHIN] = 1'b1;
        hold($urandom_range(60, 8));
        sw[wscs_pkg::B_PREHIN] = 1'b0;
        hold($urandom_range(12, 8));
        interrupt();
        sw[wscs_pkg::B_COOLIN] = 1'b1;
        hold($urandom_range(60, 8));
        sw[wscs_pkg::B_COOLIN] = 1'b0;
        hold($urandom_range(12, 8));
        interrupt();
    endtask

    initial
    begin
        int p;
        int goal;
        int r;
        int k;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Priming request with every bit high, then all low until the debounce clears,
        // then all high again so restart, stop and start rise together.
        send_tick(7'h7F, 1'b1, 10'h3FF, 10'h3FF);
        repeat (8) send_tick(7'h00, 1'b0, 10'h000, 10'h000);
        repeat (9) send_tick(7'h7F, 1'b1, 10'h3FF, 10'h000);
        send_tick(7'h2A, 1'b0, 10'h155, 10'h2AA);
        send_tick(7'h55, 1'b1, 10'h2AA, 10'h155);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drain();
            case (p)
                1:
                begin
                    set_timing(10'd0, 10'h3FF);
                    write_reg(CFG_SPARE_A, 10'($urandom_range(1023)));
                    write_reg(CFG_SPARE_B, 10'($urandom_range(1023)));
                    idle_pct  = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    set_timing(10'd1023, 10'd255);
                    idle_pct  = 0;
                    stall_pct = 83;
                end
                3:
                begin
                    set_timing(10'd1, 10'd1);
                    idle_pct  = 26;
                    stall_pct = 26;
                end
                4:
                begin
                    set_timing(10'($urandom_range(1023)), 10'($urandom_range(255, 1)));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                5:
                begin
                    set_timing(10'($urandom_range(1023)), 10'($urandom_range(255, 1)));
                    idle_pct  = 83;
                    stall_pct = 0;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase

            goal = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    run_cycle();
                else if (r < 88)
                begin
                    sw      = 7'($urandom_range(127));
                    rst_btn = 1'($urandom_range(1));
                    hold($urandom_range(12, 8));
                end
                else
                begin
                    for (k = $urandom_range(20, 4); k > 0; k--)
                        send_tick(7'($urandom_range(127)), 1'($urandom_range(1)),
                                  10'($urandom_range(1023)), 10'($urandom_range(1023)));
                end
            end
        end

        wait_drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
